/* rtl/shs_pkg.sv */
// Shared types, constants and round functions of the SHA-256 stream hasher.
package shs_pkg;

    typedef logic [31:0] shs_word_t;

    // Eight 32-bit words; index 0 is word a (or H0), index 7 is word h (or H7).
    typedef logic [7:0][31:0] shs_hash_t;

    // Controls from the byte sequencer to the compression unit.
    typedef struct packed {
        logic load_word;
        logic start;
    } shs_ctrl_t;

    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned ROUNDS      = 64;

    localparam logic [5:0] LAST_ROUND = 6'(ROUNDS - 1);
    localparam logic [5:0] LAST_BYTE  = 6'(BLOCK_BYTES - 1);
    localparam logic [5:0] LENGTH_POS = 6'd56;
    localparam logic [7:0] PAD_MARK   = 8'h80;

    localparam shs_hash_t HASH_INIT = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam shs_word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic shs_word_t big_sigma0(input shs_word_t x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic shs_word_t big_sigma1(input shs_word_t x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic shs_word_t small_sigma0(input shs_word_t x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic shs_word_t small_sigma1(input shs_word_t x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

/* rtl/shs_compress.sv */
// SHA-256 compression unit: message schedule window and one round per cycle.
module shs_compress (
    input  logic              aclk,
    input  logic              aresetn,
    input  shs_pkg::shs_ctrl_t ctrl_i,
    input  shs_pkg::shs_word_t word_i,
    input  shs_pkg::shs_hash_t hash_i,
    output logic              done_o,
    output shs_pkg::shs_hash_t work_o
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [5:0]          round_reg, round_next;
    shs_pkg::shs_hash_t  work_reg, work_next;
    logic [15:0][31:0]   win_reg, win_next;

    shs_pkg::shs_word_t  t1, t2, sched_word, ch, maj;

    always_comb begin
        // Choose and majority of the working words.
        ch  = work_reg[6] ^ (work_reg[4] & (work_reg[5] ^ work_reg[6]));
        maj = (work_reg[0] & work_reg[1]) | (work_reg[2] & (work_reg[0] | work_reg[1]));
        t1  = work_reg[7] + shs_pkg::big_sigma1(work_reg[4]) + ch
              + shs_pkg::ROUND_K[round_reg] + win_reg[0];
        t2  = shs_pkg::big_sigma0(work_reg[0]) + maj;
        // The window holds W[r] .. W[r+15]; this is W[r+16].
        sched_word = shs_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                     + shs_pkg::small_sigma0(win_reg[1]) + win_reg[0];

        busy_next  = busy_reg;
        round_next = round_reg;
        work_next  = work_reg;
        win_next   = win_reg;
        done_next  = 1'b0;

        if (ctrl_i.load_word) begin
            win_next = {word_i, win_reg[15:1]};
        end else if (busy_reg) begin
            win_next = {sched_word, win_reg[15:1]};
        end

        if (ctrl_i.start) begin
            work_next  = hash_i;
            round_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            work_next  = {work_reg[6:4], work_reg[3] + t1, work_reg[2:0], t1 + t2};
            round_next = round_reg + 6'd1;
            if (round_reg == shs_pkg::LAST_ROUND) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            round_reg <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        win_reg  <= win_next;
    end

    assign done_o = done_reg;
    assign work_o = work_reg;

endmodule

/* rtl/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: byte gathering, padding and digest output.
//
// The hasher takes a message one byte per input transaction and returns its
// SHA-256 digest as eight output transactions, word 0 first, after the
// transaction that carries the end-of-message flag. Every 64th byte starts
// a compression that runs 64 rounds on the single round unit followed by
// the final hash add, during which s_ready is low. On the end-of-message
// transaction the hasher feeds the 0x80 mark, the zero fill and the eight
// length bytes through the same byte path, one per cycle but paused while
// one or two compressions run, and then offers the digest words one per
// cycle as m_ready allows. After the last digest word the hash state, bit
// count and byte count return to their initial values and s_ready rises
// again. An input transaction with neither a byte nor the end flag changes
// nothing.
module sha256_stream_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_byte_valid,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);

    // Sequencer states.
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_COMP = 3'd1;
    localparam logic [2:0] S_MARK = 3'd2;
    localparam logic [2:0] S_ZERO = 3'd3;
    localparam logic [2:0] S_LEN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // Which kind of block the running compression belongs to.
    localparam logic [1:0] PH_DATA = 2'd0;  // block of message bytes
    localparam logic [1:0] PH_PAD  = 2'd1;  // padding block, length still to come
    localparam logic [1:0] PH_DONE = 2'd2;  // block that ends with the length

    localparam logic [2:0] LAST_INDEX = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [1:0]         phase_reg, phase_next;
    logic               fin_reg, fin_next;
    logic [5:0]         fill_reg, fill_next;
    logic [63:0]        bit_length_reg, bit_length_next;
    logic [63:0]        total_reg, total_next;
    logic [23:0]        acc_reg, acc_next;
    logic [2:0]         out_idx_reg, out_idx_next;
    shs_pkg::shs_hash_t hash_reg, hash_next;

    logic               push_en;
    logic [7:0]         push_byte;
    logic               comp_done;
    shs_pkg::shs_ctrl_t ctrl;
    shs_pkg::shs_hash_t work;

    // One round per cycle against the stored hash; the schedule window is
    // filled a word at a time from the byte path below.
    shs_compress u_compress (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl_i  (ctrl),
        .word_i  ({acc_reg, push_byte}),
        .hash_i  (hash_reg),
        .done_o  (comp_done),
        .work_o  (work)
    );

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        fin_next        = fin_reg;
        bit_length_next = bit_length_reg;
        total_next      = total_reg;
        out_idx_next    = out_idx_reg;
        hash_next       = hash_reg;
        push_en         = 1'b0;
        push_byte       = 8'h00;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    fin_next   = s_end_of_message;
                    phase_next = PH_DATA;
                    if (s_byte_valid) begin
                        push_en   = 1'b1;
                        push_byte = s_data_byte;
                    end
                    if (s_byte_valid && fill_reg == shs_pkg::LAST_BYTE) begin
                        state_next = S_COMP;
                    end else if (s_end_of_message) begin
                        state_next = S_MARK;
                    end
                end
            end
            S_COMP: begin
                if (comp_done) begin
                    for (int i = 0; i < 8; i++) begin
                        hash_next[i] = hash_reg[i] + work[i];
                    end
                    // Only message blocks count toward the length.
                    if (phase_reg == PH_DATA) begin
                        bit_length_next = bit_length_reg + 64'd512;
                    end
                    if (!fin_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        priority case (phase_reg)
                            PH_DATA: state_next = S_MARK;
                            PH_PAD:  state_next = S_ZERO;
                            default: begin
                                state_next   = S_OUT;
                                out_idx_next = '0;
                            end
                        endcase
                    end
                end
            end
            S_MARK: begin
                // The length is fixed here: completed blocks plus held bytes.
                total_next = bit_length_reg + {55'd0, fill_reg, 3'b000};
                push_en    = 1'b1;
                push_byte  = shs_pkg::PAD_MARK;
                phase_next = PH_PAD;
                state_next = (fill_reg == shs_pkg::LAST_BYTE) ? S_COMP : S_ZERO;
            end
            S_ZERO: begin
                if (fill_reg == shs_pkg::LENGTH_POS) begin
                    state_next = S_LEN;
                end else begin
                    push_en = 1'b1;
                    if (fill_reg == shs_pkg::LAST_BYTE) begin
                        state_next = S_COMP;
                    end
                end
            end
            S_LEN: begin
                push_en    = 1'b1;
                push_byte  = total_reg[63:56];
                total_next = {total_reg[55:0], 8'h00};
                if (fill_reg == shs_pkg::LAST_BYTE) begin
                    phase_next = PH_DONE;
                    state_next = S_COMP;
                end
            end
            S_OUT: begin
                if (m_ready) begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == LAST_INDEX) begin
                        hash_next       = shs_pkg::HASH_INIT;
                        bit_length_next = '0;
                        fin_next        = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Shared byte path: gather big-endian words and start a compression on
    // the 64th byte of a block.
    always_comb begin
        acc_next       = acc_reg;
        fill_next      = fill_reg;
        ctrl.load_word = 1'b0;
        ctrl.start     = 1'b0;
        if (push_en) begin
            acc_next       = {acc_reg[15:0], push_byte};
            fill_next      = fill_reg + 6'd1;
            ctrl.load_word = (fill_reg[1:0] == 2'd3);
            ctrl.start     = (fill_reg == shs_pkg::LAST_BYTE);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_DATA;
            fin_reg        <= 1'b0;
            fill_reg       <= '0;
            bit_length_reg <= '0;
            out_idx_reg    <= '0;
            hash_reg       <= shs_pkg::HASH_INIT;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            fin_reg        <= fin_next;
            fill_reg       <= fill_next;
            bit_length_reg <= bit_length_next;
            out_idx_reg    <= out_idx_next;
            hash_reg       <= hash_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg <= total_next;
        acc_reg   <= acc_next;
    end

    assign s_ready       = (state_reg == S_IDLE);
    assign m_valid       = (state_reg == S_OUT);
    assign m_digest_word = hash_reg[out_idx_reg];
    assign m_word_index  = out_idx_reg;
    assign m_last_word   = (out_idx_reg == LAST_INDEX);

`ifndef NO_ASSERTIONS
    // A word enters the schedule window only on the fourth byte of that word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_word |-> fill_reg[1:0] == 2'd3)
        else $error("schedule word loaded off a word boundary");

    // The compression unit reports completion only while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        comp_done |-> state_reg == S_COMP)
        else $error("compression finished outside the compression state");

    // An end-of-message transaction always holds off the next input.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_end_of_message) |=> !s_ready)
        else $error("input accepted while a digest is pending");

    // After the last digest word the hasher is back at a block boundary and ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_word) |=> (s_ready && fill_reg == '0))
        else $error("hasher not restarted after the digest");
`endif

endmodule
